// File: sv/utf8_to_utf32_decoder_core_assert.svh
// Assertion helpers shared by the decoder modules.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef UTF8_TO_UTF32_DECODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF32_DECODER_CORE_ASSERT_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define U8D_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// expr must never hold.
`define U8D_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// File: sv/u8d_pkg.sv
package u8d_pkg;

	localparam int unsigned CpW    = 21;
	localparam int unsigned CountW = 17;
	localparam int unsigned DepthW = 2;
	localparam int unsigned Depth  = 1 << DepthW;

	localparam logic [32:0]       MAX_LEN    = 33'd65536;
	localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};
	localparam logic [CountW-1:0] CountLimit =
		(MAX_LEN > {16'd0, CountMax}) ? CountMax : MAX_LEN[CountW-1:0];

	localparam logic [7:0] ContMask  = 8'b1100_0000;
	localparam logic [7:0] ContPat   = 8'b1000_0000;
	localparam logic [7:0] Lead2Mask = 8'b1110_0000;
	localparam logic [7:0] Lead2Pat  = 8'b1100_0000;
	localparam logic [7:0] Lead3Mask = 8'b1111_0000;
	localparam logic [7:0] Lead3Pat  = 8'b1110_0000;
	localparam logic [7:0] Lead4Mask = 8'b1111_1000;
	localparam logic [7:0] Lead4Pat  = 8'b1111_0000;

	localparam logic [CpW-1:0] Min2   = 21'h000080;
	localparam logic [CpW-1:0] Max2   = 21'h0007FF;
	localparam logic [CpW-1:0] Min3   = 21'h000800;
	localparam logic [CpW-1:0] SurLo  = 21'h00D7FF;
	localparam logic [CpW-1:0] SurHi  = 21'h00E000;
	localparam logic [CpW-1:0] Max3   = 21'h00FFFF;
	localparam logic [CpW-1:0] MaxCp  = 21'h10FFFF;

	// At most one decoded event per accepted byte: a code point, an end summary, or both.
	typedef struct packed {
		logic              has_cp;
		logic [CpW-1:0]    cp;
		logic              has_end;
		logic              err;
		logic [CountW-1:0] count;
	} u8d_rec_t;

	// Output beat as held in the back end's output register.
	typedef struct packed {
		logic [CpW-1:0]    cp;
		logic              is_end;
		logic              error;
		logic [CountW-1:0] count;
	} u8d_beat_t;

	// Range check of a finished multi-byte value; seqlen is length minus one.
	function automatic logic value_ok(input logic [CpW-1:0] v, input logic [1:0] seqlen);
		logic ok;
		begin
			unique case (seqlen)
				2'd1: ok = (v >= Min2) && (v <= Max2);
				2'd2: ok = (v >= Min3) && (v <= Max3) && !((v > SurLo) && (v < SurHi));
				default: ok = (v > Max3) && (v <= MaxCp);
			endcase
			return ok;
		end
	endfunction

endpackage

// File: sv/u8d_front.sv
module u8d_front
	import u8d_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     byte_in,
	input  logic           last_byte,
	output logic           push,
	output u8d_rec_t       rec
);

	logic [1:0]        pend_q, seqlen_q;
	logic [CpW-1:0]    pv_q;
	logic              failed_q;
	logic [CountW-1:0] cnt_q;

	logic [1:0]        pend_n, seqlen_n;
	logic [CpW-1:0]    pv_n, pv_shift;
	logic              failed_n, fail_end, cp_hit;
	logic [CpW-1:0]    cp_val;
	logic [CountW-1:0] cnt_n;

	always_comb begin
		pend_n   = pend_q;
		seqlen_n = seqlen_q;
		pv_n     = pv_q;
		failed_n = failed_q;
		cp_hit   = 1'b0;
		cp_val   = '0;
		pv_shift = {pv_q[CpW-7:0], byte_in[5:0]};
		if (!failed_q) begin
			if (pend_q == 2'd0) begin
				if (!byte_in[7]) begin
					cp_hit = 1'b1;
					cp_val = {13'd0, byte_in};
				end else if ((byte_in & Lead2Mask) == Lead2Pat) begin
					pv_n = {16'd0, byte_in[4:0]};
					pend_n = 2'd1;
					seqlen_n = 2'd1;
				end else if ((byte_in & Lead3Mask) == Lead3Pat) begin
					pv_n = {17'd0, byte_in[3:0]};
					pend_n = 2'd2;
					seqlen_n = 2'd2;
				end else if ((byte_in & Lead4Mask) == Lead4Pat) begin
					pv_n = {18'd0, byte_in[2:0]};
					pend_n = 2'd3;
					seqlen_n = 2'd3;
				end else begin
					failed_n = 1'b1;
				end
			end else if ((byte_in & ContMask) != ContPat) begin
				failed_n = 1'b1;
			end else begin
				pv_n = pv_shift;
				pend_n = pend_q - 2'd1;
				if (pend_q == 2'd1) begin
					if (value_ok(pv_shift, seqlen_q)) begin
						cp_hit = 1'b1;
						cp_val = pv_shift;
					end else begin
						failed_n = 1'b1;
					end
					pv_n = '0;
					seqlen_n = 2'd0;
				end
			end
		end
		cnt_n = (cp_hit && (cnt_q < CountLimit)) ? cnt_q + 1'b1 : cnt_q;
		fail_end = failed_n || (pend_n != 2'd0);
	end

	always_comb begin
		rec.has_cp  = cp_hit;
		rec.cp      = cp_val;
		rec.has_end = last_byte;
		rec.err     = fail_end;
		rec.count   = fail_end ? '0 : cnt_n;
		push        = accept && (cp_hit || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			seqlen_q <= '0;
			pv_q     <= '0;
			failed_q <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pend_q   <= '0;
				seqlen_q <= '0;
				pv_q     <= '0;
				failed_q <= 1'b0;
				cnt_q    <= '0;
			end else begin
				pend_q   <= pend_n;
				seqlen_q <= seqlen_n;
				pv_q     <= pv_n;
				failed_q <= failed_n;
				cnt_q    <= cnt_n;
			end
		end
	end

endmodule

// File: sv/u8d_fifo.sv
module u8d_fifo
	import u8d_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  u8d_rec_t wr_rec,
	input  logic     pop,
	output logic     full,
	output logic     empty,
	output u8d_rec_t head
);

	u8d_rec_t          mem_q [Depth];
	logic [DepthW-1:0] wr_ptr_q, rd_ptr_q;
	logic [DepthW:0]   fill_q;

	assign full  = (fill_q == (DepthW+1)'(Depth));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

`include "utf8_to_utf32_decoder_core_assert.svh"

	`U8D_ASSERT_NEVER(a_no_overflow, push && full, "push into a full queue")
	`U8D_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from an empty queue")
	`U8D_ASSERT_IMP(a_fill_ptrs, fill_q != (DepthW+1)'(Depth),
		fill_q[DepthW-1:0] == DepthW'(wr_ptr_q - rd_ptr_q), "fill count and pointers disagree")

endmodule

// File: sv/u8d_back.sv
module u8d_back
	import u8d_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  u8d_rec_t  head,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output u8d_beat_t out_beat
);

	logic      valid_q;
	logic      phase_q;
	u8d_beat_t beat_q;
	logic      load;
	logic      send_cp;

	// Load a new beat when the output register is free or being drained.
	assign load    = !empty && (!valid_q || out_ready);
	assign send_cp = head.has_cp && !phase_q;
	assign pop     = load && !(send_cp && head.has_end);

	assign out_valid = valid_q;
	assign out_beat  = beat_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_cp) begin
				beat_q <= '{cp: head.cp, is_end: 1'b0, error: 1'b0, count: '0};
			end else begin
				beat_q <= '{cp: '0, is_end: 1'b1, error: head.err, count: head.count};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				phase_q <= send_cp && head.has_end;
			end
		end
	end

`include "utf8_to_utf32_decoder_core_assert.svh"

	`U8D_ASSERT_IMP(a_phase_head, phase_q,
		!empty && head.has_cp && head.has_end, "second half pending without a split record")
	`U8D_ASSERT_IMP(a_cp_beat_clean, valid_q && !beat_q.is_end,
		!beat_q.error && (beat_q.count == '0), "code point beat carries summary bits")
	`U8D_ASSERT_IMP(a_pop_loads, pop, load, "record retired without a beat")

endmodule

// File: sv/utf8_to_utf32_decoder_core.sv
// Channel  Dir  Fields (lowest bit first)                    Marks
// s_*      in   tdata: byte_in[7:0]                          tlast: last_byte
// m_*      out  tdata: scalar[20:0], count[37:21], pad      tlast: is_end, tuser: error
//
// One byte is accepted per cycle while the queue has room; decode and validation finish in the accepting cycle.
// A byte that ends a code point and also ends the buffer yields two beats, which the
// output side sends one after the other, code point first.
// A four-entry event queue between decoder and output register absorbs those extra
// beats and downstream stalls; s_tready drops only while the queue is full.
// An accepted byte reaches the output through the event queue and then the output register.
// arst_n clears decoder state, queue pointers and the output valid at once.
module utf8_to_utf32_decoder_core
	import u8d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // scalar[20:0], count[37:21], zero[39:38]
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // error[0]
);

	logic      accept;
	logic      push, pop, full, empty;
	u8d_rec_t  rec, head;
	u8d_beat_t beat;

	// Accept a beat whenever the queue has room for its event.
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// Front: classify the byte, update sequence state and emit at most one event.
	u8d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.byte_in   (s_tdata),
		.last_byte (s_tlast),
		.push      (push),
		.rec       (rec)
	);

	// Queue: decouple decoding from the output handshake.
	u8d_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (rec),
		.pop    (pop),
		.full   (full),
		.empty  (empty),
		.head   (head)
	);

	// Back: turn each event into a code point beat, an end beat, or both.
	u8d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_beat  (beat)
	);

	assign m_tdata = {2'b00, beat.count, beat.cp};
	assign m_tlast = beat.is_end;
	assign m_tuser = beat.error;

endmodule
